// ----- rtl/dss_pkg.sv -----
// Shared types, codes and constants of the step dependency scheduler.
package dss_pkg;

  localparam int MAX_STEPS_DEF   = 16;
  localparam int MAX_DEPS_DEF    = 4;
  localparam int RESULT_CAP      = 16;
  localparam logic [1:0] MAX_RETRIES_RST = 2'd2;
  localparam logic [7:0] CNT_SAT = 8'hFF;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_DEP   = 3'd2;
  localparam logic [2:0] CMD_SCAN  = 3'd3;
  localparam logic [2:0] CMD_DONE  = 3'd4;
  localparam logic [2:0] CMD_FAIL  = 3'd5;
  localparam logic [2:0] CMD_QUERY = 3'd6;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_FAILED  = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_BAD_ID   = 2'd2;
  localparam logic [1:0] ERR_DEP_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] step_id;
    logic [5:0] dep_id;
    logic [4:0] max_ready;
  } in_t;

  typedef struct packed {
    logic [3:0] ready_step;
    logic [1:0] error_code;
    logic       found;
    logic       last;
    logic       complete;
    logic [4:0] steps_in_use;
    logic [7:0] done_total;
    logic [7:0] failed_total;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_EMIT, S_SC_STEP, S_SC_DEP, S_SC_DWT, S_SC_FIN,
    S_FW_STEP, S_FW_DEP, S_FW_DWT
  } state_t;

  typedef enum logic [1:0] {EM_SINGLE, EM_HELD_MID, EM_HELD_LAST, EM_NONE} emit_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    logic  step_next;
    logic  dep_init;
    logic  dep_rd;
    logic  sc_chk;
    logic  fw_chk;
    logic  mark_ready;
    logic  emit;
    emit_t emit_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic       is_scan;
    logic       fail_final;
    logic       scan_end;
    logic       fw_end;
    logic       cur_pending;
    logic       deps_end;
    logic       deps_ok;
    logic       held_v;
    logic       out_room;
  } ctl_sts_t;

endpackage

// ----- rtl/dss_ctrl.sv -----
// Command sequencer of the step dependency scheduler.
module dss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dss_pkg::ctl_sts_t sts,
  output dss_pkg::ctl_cmd_t cmd
);
  import dss_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.is_scan) state_nxt = S_SC_STEP;
        else if (sts.fail_final) state_nxt = S_FW_STEP;
        else state_nxt = S_EMIT;
      end
      S_EMIT:    if (sts.out_room) state_nxt = S_IDLE;
      S_SC_STEP: begin
        if (sts.scan_end) state_nxt = S_SC_FIN;
        else if (sts.cur_pending) state_nxt = S_SC_DEP;
      end
      S_SC_DEP: begin
        if (!sts.deps_end) state_nxt = S_SC_DWT;
        else if (!sts.deps_ok || !sts.held_v || sts.out_room) state_nxt = S_SC_STEP;
      end
      S_SC_DWT:  state_nxt = S_SC_DEP;
      S_SC_FIN:  if (sts.out_room) state_nxt = S_IDLE;
      S_FW_STEP: state_nxt = sts.fw_end ? S_EMIT : S_FW_DEP;
      S_FW_DEP:  state_nxt = sts.deps_end ? S_FW_STEP : S_FW_DWT;
      S_FW_DWT:  state_nxt = S_FW_DEP;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_kind = EM_SINGLE;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_EMIT: cmd.emit = sts.out_room;
      S_SC_STEP: begin
        if (!sts.scan_end) begin
          if (sts.cur_pending) cmd.dep_init = 1'b1;
          else cmd.step_next = 1'b1;
        end
      end
      S_SC_DEP: begin
        if (!sts.deps_end) begin
          cmd.dep_rd = 1'b1;
        end else if (!sts.deps_ok) begin
          cmd.step_next = 1'b1;
        end else if (!sts.held_v) begin
          cmd.mark_ready = 1'b1;
        end else if (sts.out_room) begin
          cmd.mark_ready = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_HELD_MID;
        end
      end
      S_SC_DWT: cmd.sc_chk = 1'b1;
      S_SC_FIN: begin
        cmd.emit = sts.out_room;
        cmd.emit_kind = sts.held_v ? EM_HELD_LAST : EM_NONE;
      end
      S_FW_STEP: if (!sts.fw_end) cmd.dep_init = 1'b1;
      S_FW_DEP: begin
        if (sts.deps_end) cmd.step_next = 1'b1;
        else cmd.dep_rd = 1'b1;
      end
      S_FW_DWT: cmd.fw_chk = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/dss_datapath.sv -----
// Step table, dependency memory, counters and result register of the scheduler.
module dss_datapath #(
  parameter int MAX_STEPS = dss_pkg::MAX_STEPS_DEF,
  parameter int MAX_DEPS  = dss_pkg::MAX_DEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dss_pkg::in_t      in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              out_stall,
  output logic              out_valid,
  output dss_pkg::out_t     out_data,
  input  dss_pkg::ctl_cmd_t cmd,
  output dss_pkg::ctl_sts_t sts
);
  import dss_pkg::*;

  localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int DW = $clog2(MAX_DEPS + 1);
  localparam int ND = MAX_STEPS * MAX_DEPS;
  localparam int AW = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [AW-1:0] MD = AW'(MAX_DEPS);

  logic [2:0]    status_r [MAX_STEPS];
  logic [1:0]    retry_r  [MAX_STEPS];
  logic [DW-1:0] depcnt_r [MAX_STEPS];
  logic [5:0]    dep_mem  [ND];

  logic [1:0]    max_retries_r;
  logic [2:0]    cmd_r;
  logic [5:0]    sid_r, did_r;
  logic [4:0]    lim_r, n_r;
  logic [CW-1:0] total_r, active_r, idx_r;
  logic [DW-1:0] dix_r;
  logic [IW-1:0] held_r;
  logic          held_v_r, ok_r, out_valid_r;
  logic [7:0]    done_r, failed_r;
  logic [5:0]    dep_rd_r;
  logic [3:0]    res_rs_r;
  logic [1:0]    res_err_r;
  logic          res_found_r;
  out_t          out_r;

  logic [IW-1:0] ra, total_ix;
  logic [2:0]    rd_st;
  logic [DW-1:0] rd_dc;
  logic          bad, act_old, retry_ok, id_in, room;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          dep_wr;

  assign ra = cmd.exec ? sid_r[IW-1:0] : (cmd.sc_chk ? dep_rd_r[IW-1:0] : idx_r[IW-1:0]);
  assign total_ix = total_r[IW-1:0];
  assign rd_st    = status_r[ra];
  assign rd_dc    = depcnt_r[ra];
  assign bad      = 7'(sid_r) >= 7'(total_r);
  assign act_old  = (rd_st == ST_PENDING) || (rd_st == ST_READY);
  assign retry_ok = retry_r[ra] < max_retries_r;
  assign id_in    = 7'(dep_rd_r) < 7'(total_r);
  assign room     = !out_valid_r || !out_stall;
  assign wr_addr  = AW'(ra) * MD + AW'(rd_dc);
  assign rd_addr  = AW'(ra) * MD + AW'(dix_r);
  assign dep_wr   = cmd.exec && (cmd_r == CMD_DEP) && !bad && (32'(rd_dc) < MAX_DEPS);

  always_comb begin
    sts.is_scan     = cmd_r == CMD_SCAN;
    sts.fail_final  = (cmd_r == CMD_FAIL) && !bad && !retry_ok;
    sts.scan_end    = (idx_r >= total_r) || (n_r >= lim_r);
    sts.fw_end      = idx_r >= total_r;
    sts.cur_pending = rd_st == ST_PENDING;
    sts.deps_end    = dix_r >= rd_dc;
    sts.deps_ok     = ok_r;
    sts.held_v      = held_v_r;
    sts.out_room    = room;
  end

  always_ff @(posedge clk) begin
    if (dep_wr) dep_mem[wr_addr] <= did_r;
    if (cmd.dep_rd) dep_rd_r <= dep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (cmd_r)
        CMD_ADD: if (32'(total_r) < MAX_STEPS) begin
          status_r[total_ix] <= ST_PENDING;
          retry_r[total_ix]  <= '0;
          depcnt_r[total_ix] <= '0;
        end
        CMD_DEP:  if (dep_wr) depcnt_r[ra] <= rd_dc + 1'b1;
        CMD_DONE: if (!bad) status_r[ra] <= ST_DONE;
        CMD_FAIL: if (!bad) begin
          if (retry_ok) begin
            retry_r[ra]  <= retry_r[ra] + 1'b1;
            status_r[ra] <= ST_PENDING;
          end else begin
            status_r[ra] <= ST_FAILED;
          end
        end
        default: ;
      endcase
    end else if (cmd.mark_ready) begin
      status_r[ra] <= ST_READY;
    end else if (cmd.fw_chk && (dep_rd_r == sid_r)) begin
      status_r[ra] <= ST_BLOCKED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_data.cmd;
      sid_r <= in_data.step_id;
      did_r <= in_data.dep_id;
      lim_r <= (32'(in_data.max_ready) > RESULT_CAP) ? 5'(RESULT_CAP) : in_data.max_ready;
    end
    if (cmd.exec) begin
      res_rs_r    <= '0;
      res_err_r   <= ERR_OK;
      res_found_r <= 1'b0;
      unique case (cmd_r)
        CMD_ADD: begin
          if (32'(total_r) >= MAX_STEPS) res_err_r <= ERR_FULL;
          else begin
            res_rs_r    <= 4'(total_r);
            res_found_r <= 1'b1;
          end
        end
        CMD_DEP: begin
          if (bad) res_err_r <= ERR_BAD_ID;
          else if (!dep_wr) res_err_r <= ERR_DEP_FULL;
        end
        CMD_DONE, CMD_FAIL: if (bad) res_err_r <= ERR_BAD_ID;
        default: ;
      endcase
      idx_r    <= '0;
      n_r      <= '0;
      held_v_r <= 1'b0;
    end
    if (cmd.step_next) idx_r <= idx_r + 1'b1;
    if (cmd.dep_init) begin
      dix_r <= '0;
      ok_r  <= 1'b1;
    end
    if (cmd.sc_chk) begin
      if (id_in && (rd_st != ST_DONE)) ok_r <= 1'b0;
      dix_r <= dix_r + 1'b1;
    end
    if (cmd.fw_chk) dix_r <= dix_r + 1'b1;
    if (cmd.mark_ready) begin
      held_r   <= idx_r[IW-1:0];
      held_v_r <= 1'b1;
      n_r      <= n_r + 1'b1;
      idx_r    <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= MAX_RETRIES_RST;
      total_r  <= '0;
      active_r <= '0;
      done_r   <= '0;
      failed_r <= '0;
    end else begin
      if (cfg_we) max_retries_r <= cfg_wdata;
      if (cmd.exec) begin
        unique case (cmd_r)
          CMD_CLEAR: begin
            total_r  <= '0;
            active_r <= '0;
            done_r   <= '0;
            failed_r <= '0;
          end
          CMD_ADD: if (32'(total_r) < MAX_STEPS) begin
            total_r  <= total_r + 1'b1;
            active_r <= active_r + 1'b1;
          end
          CMD_DONE: if (!bad) begin
            if (act_old) active_r <= active_r - 1'b1;
            if (done_r != CNT_SAT) done_r <= done_r + 1'b1;
          end
          CMD_FAIL: if (!bad) begin
            if (retry_ok) begin
              if (!act_old) active_r <= active_r + 1'b1;
            end else begin
              if (act_old) active_r <= active_r - 1'b1;
              if (failed_r != CNT_SAT) failed_r <= failed_r + 1'b1;
            end
          end
          default: ;
        endcase
      end else if (cmd.fw_chk && (dep_rd_r == sid_r) && act_old) begin
        active_r <= active_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.complete     <= active_r == '0;
      out_r.steps_in_use <= 5'(total_r);
      out_r.done_total   <= done_r;
      out_r.failed_total <= failed_r;
      out_r.error_code   <= ERR_OK;
      unique case (cmd.emit_kind)
        EM_SINGLE: begin
          out_r.ready_step <= res_rs_r;
          out_r.error_code <= res_err_r;
          out_r.found      <= res_found_r;
          out_r.last       <= 1'b1;
        end
        EM_HELD_MID: begin
          out_r.ready_step <= 4'(held_r);
          out_r.found      <= 1'b1;
          out_r.last       <= 1'b0;
        end
        EM_HELD_LAST: begin
          out_r.ready_step <= 4'(held_r);
          out_r.found      <= 1'b1;
          out_r.last       <= 1'b1;
        end
        default: begin
          out_r.ready_step <= '0;
          out_r.found      <= 1'b0;
          out_r.last       <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/dag_step_dependency_scheduler.sv -----
// Top level of the step dependency scheduler.
// One command item at a time: a plain command passes the EXEC and EMIT states; a
// ready scan visits SC_STEP for each step and SC_DEP and SC_DWT for each dependency
// of each pending step, and a final failure sweeps every step's dependency list
// through FW_STEP, FW_DEP and FW_DWT, reading each entry through the single read port of
// the dependency memory. Results leave through an output register, so a stalled
// result does not hold up the ready scan until the next result must be placed.
module dag_step_dependency_scheduler #(
  parameter int MAX_STEPS = dss_pkg::MAX_STEPS_DEF,
  parameter int MAX_DEPS  = dss_pkg::MAX_DEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dss_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);
  import dss_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  dss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  dss_datapath #(.MAX_STEPS(MAX_STEPS), .MAX_DEPS(MAX_DEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .out_stall(out_stall), .out_valid(out_valid),
    .out_data(out_data), .cmd(cmd), .sts(sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("accepted item did not hold input");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.steps_in_use) <= MAX_STEPS))
    else $error("steps in use above table size");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.ready_step == '0 && out_data.last))
    else $error("empty result carries an id or is not final");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.error_code == ERR_OK))
    else $error("reported step carries an error");

endmodule
